// ----- sv/rect_overlap_table_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the rectangle overlap table
// Concurrent assertion forms used by the rot_back RTL module.
// ---------------------------------------------------------------------------
`ifndef RECT_OVERLAP_TABLE_DEFINES_SVH
`define RECT_OVERLAP_TABLE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define ROT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ROT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rot_pkg.sv -----
// ---------------------------------------------------------------------------
// Rectangle overlap table package
// Command and status codes, back end state codes and output field widths.
// ---------------------------------------------------------------------------
package rot_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_HIT       = 3'd4,
        ST_NO_HIT    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_MOVE,
        BK_WAIT,
        BK_EMIT
    } bk_state_t;

    localparam int unsigned FILL_BITS = 7;
    localparam int unsigned OUT_TAG_BITS = 32;

endpackage

// ----- sv/rect_overlap_table.sv -----
// ---------------------------------------------------------------------------
// Rectangle overlap table
// Flat table of tagged rectangles with insert, remove, clear and overlap query.
// ---------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tdata: cmd, tag, x_low, y_low, x_high, y_high
//  m_axis   | out       | tdata: status, hit_tag, fill; tlast: is_last
//
// Insert and clear need no scan. Remove and query scan the stored entries
// through the table memory's registered read port, one entry a cycle while
// no query hit is held by a stalled result output, which holds the scan on
// the current entry.
// A two-entry command queue lets new commands be accepted while one is at work.
// Reset clears the entry count and the control state; no clearing pass is run.
// ---------------------------------------------------------------------------
module rect_overlap_table
    import rot_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int TAG_BITS   = 32,
    parameter int COORD_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], tag, x_low, y_low, x_high, y_high, zero pad
    input  logic [((2 + TAG_BITS + 4*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], hit_tag[34:3], fill[41:35], zero pad[47:42]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int IW = 2 + TAG_BITS + 4 * COORD_BITS;

    logic          q_valid;
    logic          q_ready;
    logic [IW-1:0] q_data;
    logic [2:0]    st;
    logic [31:0]   tg;
    logic [6:0]    fl;

    rot_front #(.W(IW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata[IW-1:0]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    rot_back #(
        .CAPACITY   (CAPACITY),
        .TAG_BITS   (TAG_BITS),
        .COORD_BITS (COORD_BITS),
        .IW         (IW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (st),
        .out_tag    (tg),
        .out_last   (m_axis_tlast),
        .out_fill   (fl)
    );

    assign m_axis_tdata = {6'd0, fl, tg, st};

endmodule

// ----- sv/rot_front.sv -----
// ---------------------------------------------------------------------------
// Rectangle overlap table front end
// Accepts commands into a two-entry queue toward the back end.
// ---------------------------------------------------------------------------
module rot_front
    import rot_pkg::*;
#(
    parameter int W = 98
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         q_valid,
    input  logic         q_ready,
    output logic [W-1:0] q_data
);

    logic [W-1:0] slot_reg [2];
    logic         rd_ptr_reg;
    logic         wr_ptr_reg;
    logic [1:0]   cnt_reg;
    logic         push;
    logic         pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- sv/rot_back.sv -----
// ---------------------------------------------------------------------------
// Rectangle overlap table back end
// Holds the table memories and runs each command against them.
// ---------------------------------------------------------------------------
`include "rect_overlap_table_defines.svh"

module rot_back
    import rot_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int TAG_BITS   = 32,
    parameter int COORD_BITS = 16,
    parameter int IW         = 98
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [IW-1:0] q_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    out_status,
    output logic [31:0]   out_tag,
    output logic          out_last,
    output logic [6:0]    out_fill
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = 4 * COORD_BITS;

    logic [TAG_BITS-1:0] tag_mem [CAPACITY];
    logic [RW-1:0]       rect_mem [CAPACITY];
    logic [TAG_BITS-1:0] rd_tag_reg;
    logic [RW-1:0]       rd_rect_reg;

    bk_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] hole_reg, hole_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic          any_reg, any_next;
    logic [31:0]   pend_reg, pend_next;
    cmd_t          cmd_reg, cmd_next;
    logic [TAG_BITS-1:0] ktag_reg, ktag_next;
    logic [RW-1:0]       krect_reg, krect_next;

    logic          ov_reg, ov_next;
    logic [2:0]    os_reg, os_next;
    logic [31:0]   ot_reg, ot_next;
    logic          ol_reg, ol_next;
    logic [6:0]    of_reg, of_next;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [TAG_BITS-1:0] mem_wt;
    logic [RW-1:0]       mem_wr;

    logic signed [COORD_BITS-1:0] axl, ayl, axh, ayh, bxl, byl, bxh, byh;
    logic meet;
    logic out_free;

    assign {ayh, axh, ayl, axl} = rd_rect_reg;
    assign {byh, bxh, byl, bxl} = krect_reg;
    assign meet = (axl <= bxh) && (bxl <= axh) && (ayl <= byh) && (byl <= ayh);
    assign out_free = !ov_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_wa]  <= mem_wt;
            rect_mem[mem_wa] <= mem_wr;
        end
        rd_tag_reg  <= tag_mem[rd_addr_next];
        rd_rect_reg <= rect_mem[rd_addr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        hole_reg    <= hole_next;
        rd_addr_reg <= rd_addr_next;
        any_reg     <= any_next;
        pend_reg    <= pend_next;
        cmd_reg     <= cmd_next;
        ktag_reg    <= ktag_next;
        krect_reg   <= krect_next;
        os_reg      <= os_next;
        ot_reg      <= ot_next;
        ol_reg      <= ol_next;
        of_reg      <= of_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        hole_next    = hole_reg;
        rd_addr_next = rd_addr_reg;
        rd_ok_next   = 1'b0;
        any_next     = any_reg;
        pend_next    = pend_reg;
        cmd_next     = cmd_reg;
        ktag_next    = ktag_reg;
        krect_next   = krect_reg;
        ov_next      = ov_reg && !out_ready;
        os_next      = os_reg;
        ot_next      = ot_reg;
        ol_next      = ol_reg;
        of_next      = of_reg;
        q_ready      = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = count_reg[AW-1:0];
        mem_wt       = q_data[2 +: TAG_BITS];
        mem_wr       = q_data[2 + TAG_BITS +: RW];
        unique case (state_reg)
            BK_IDLE:
            begin
                q_ready = out_free;
                if (q_valid && out_free)
                begin
                    cmd_next   = cmd_t'(q_data[1:0]);
                    ktag_next  = q_data[2 +: TAG_BITS];
                    krect_next = q_data[2 + TAG_BITS +: RW];
                    idx_next   = '0;
                    any_next   = 1'b0;
                    rd_addr_next = '0;
                    ot_next    = '0;
                    ol_next    = 1'b1;
                    unique case (cmd_t'(q_data[1:0]))
                        CMD_INSERT:
                        begin
                            ov_next = 1'b1;
                            if (count_reg == CW'(CAPACITY))
                            begin
                                os_next = ST_FULL;
                                of_next = 7'(count_reg);
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                os_next    = ST_INSERTED;
                                of_next    = 7'(count_reg + 1'b1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ov_next    = 1'b1;
                            count_next = '0;
                            os_next    = ST_HIT;
                            of_next    = '0;
                        end
                        default:
                        begin
                            rd_ok_next = 1'b1;
                            state_next = BK_SCAN;
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                // rd_*_reg holds slot idx_reg when rd_ok_reg is set.
                if (idx_reg >= count_reg)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1;
                        ot_next = '0;
                        ol_next = 1'b1;
                        of_next = 7'(count_reg);
                        if (cmd_reg == CMD_REMOVE)
                        begin
                            os_next = ST_NOT_FOUND;
                        end
                        else if (any_reg)
                        begin
                            ov_next = 1'b0;
                            state_next = BK_EMIT;
                        end
                        else
                        begin
                            os_next = ST_NO_HIT;
                        end
                        if (state_next == BK_SCAN)
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = BK_SCAN;
                    end
                end
                else if (!rd_ok_reg)
                begin
                    rd_ok_next = 1'b1;
                end
                else if (cmd_reg == CMD_REMOVE)
                begin
                    if (rd_tag_reg == ktag_reg)
                    begin
                        hole_next    = idx_reg[AW-1:0];
                        rd_addr_next = AW'(count_reg - 1'b1);
                        state_next   = BK_MOVE;
                    end
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        rd_addr_next = AW'(idx_reg + 1'b1);
                        rd_ok_next   = 1'b1;
                    end
                end
                else
                begin
                    // Query: a hit is held back one step so the last one can be
                    // marked once the scan ends.
                    if (meet)
                    begin
                        if (out_free)
                        begin
                            if (any_reg)
                            begin
                                ov_next = 1'b1;
                                os_next = ST_HIT;
                                ot_next = pend_reg;
                                ol_next = 1'b0;
                                of_next = 7'(count_reg);
                            end
                            pend_next    = 32'(rd_tag_reg);
                            any_next     = 1'b1;
                            idx_next     = idx_reg + 1'b1;
                            rd_addr_next = AW'(idx_reg + 1'b1);
                            rd_ok_next   = 1'b1;
                        end
                        else
                        begin
                            rd_ok_next = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        rd_addr_next = AW'(idx_reg + 1'b1);
                        rd_ok_next   = 1'b1;
                    end
                end
            end
            BK_MOVE:
            begin
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (out_free)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = hole_reg;
                    mem_wt     = rd_tag_reg;
                    mem_wr     = rd_rect_reg;
                    count_next = count_reg - 1'b1;
                    ov_next    = 1'b1;
                    os_next    = ST_REMOVED;
                    ot_next    = '0;
                    ol_next    = 1'b1;
                    of_next    = 7'(count_reg - 1'b1);
                    state_next = BK_IDLE;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    os_next    = ST_HIT;
                    ot_next    = pend_reg;
                    ol_next    = 1'b1;
                    of_next    = 7'(count_reg);
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_tag    = ot_reg;
    assign out_last   = ol_reg;
    assign out_fill   = of_reg;

    `ROT_ASSERT_IMPL(a_count_cap, 1'b1, count_reg <= CW'(CAPACITY), "count over capacity")
    `ROT_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
        out_valid && $stable(out_status) && $stable(out_tag), "result changed while stalled")
    `ROT_ASSERT_IMPL(a_idle_take, q_ready, state_reg == BK_IDLE, "command taken while busy")
    `ROT_ASSERT_NEXT(a_move_wait, state_reg == BK_MOVE, state_reg == BK_WAIT, "move skipped")

endmodule

// ----- tb/rect_overlap_table_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rectangle overlap table testbench
// Drives insert, remove, clear and query commands with random idle gaps and
// output stalls, keeps its own copy of the table to predict every result,
// and compares each result with the oldest prediction.
// ---------------------------------------------------------------------------
module rect_overlap_table_test;
    import rot_pkg::*;

    localparam int CAP       = 64;
    localparam int IN_W      = 104;
    localparam int IDLE_LIMIT = 20000;

    // One predicted or observed result.
    typedef struct packed {
        status_t     status;
        logic [31:0] hit_tag;
        logic        is_last;
        logic [6:0]  fill;
    } result_t;

    // One command as it travels on the input stream.
    typedef struct packed {
        cmd_t               cmd;
        logic [31:0]        tag;
        logic signed [15:0] x_low;
        logic signed [15:0] y_low;
        logic signed [15:0] x_high;
        logic signed [15:0] y_high;
    } command_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic m_axis_tlast;

    rect_overlap_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow copy of the table, updated as each command is accepted.
    logic [31:0]        shadow_tag [CAP];
    logic signed [15:0] shadow_xl [CAP];
    logic signed [15:0] shadow_yl [CAP];
    logic signed [15:0] shadow_xh [CAP];
    logic signed [15:0] shadow_yh [CAP];
    int                 shadow_count;

    command_t pending_cmds[$];
    result_t  awaited_results[$];

    int  mismatches;
    int  idle_cycles;
    bit  stimulus_done;
    bit  hold_receiver;     // long receiver hold-off requested
    int  hold_cycles;
    bit  sender_pause;      // sender waits until all results are back
    int  send_gap;
    int  recv_gap;
    logic in_fire;          // input transaction taken at the last rising edge

    function automatic logic [IN_W-1:0] pack_command(command_t c);
        logic [IN_W-1:0] d;
        d = '0;
        d[1:0]   = c.cmd;
        d[33:2]  = c.tag;
        d[49:34] = c.x_low;
        d[65:50] = c.y_low;
        d[81:66] = c.x_high;
        d[97:82] = c.y_high;
        return d;
    endfunction

    function automatic result_t make_result(status_t s, logic [31:0] t, logic l);
        result_t r;
        r.status  = s;
        r.hit_tag = t;
        r.is_last = l;
        r.fill    = shadow_count[6:0];
        return r;
    endfunction

    // Apply one accepted command to the shadow table and queue what it yields.
    task automatic predict_table_results(command_t c);
        int  i;
        int  hits;
        int  found;
        result_t r;
        hits  = 0;
        found = -1;
        case (c.cmd)
            CMD_INSERT:
            begin
                if (shadow_count >= CAP)
                begin
                    awaited_results.push_back(make_result(ST_FULL, '0, 1'b1));
                end
                else
                begin
                    shadow_tag[shadow_count] = c.tag;
                    shadow_xl[shadow_count]  = c.x_low;
                    shadow_yl[shadow_count]  = c.y_low;
                    shadow_xh[shadow_count]  = c.x_high;
                    shadow_yh[shadow_count]  = c.y_high;
                    shadow_count++;
                    awaited_results.push_back(make_result(ST_INSERTED, '0, 1'b1));
                end
            end
            CMD_REMOVE:
            begin
                for (i = 0; i < shadow_count; i++)
                begin
                    if (found < 0 && shadow_tag[i] == c.tag)
                    begin
                        found = i;
                    end
                end
                if (found >= 0)
                begin
                    shadow_count--;
                    shadow_tag[found] = shadow_tag[shadow_count];
                    shadow_xl[found]  = shadow_xl[shadow_count];
                    shadow_yl[found]  = shadow_yl[shadow_count];
                    shadow_xh[found]  = shadow_xh[shadow_count];
                    shadow_yh[found]  = shadow_yh[shadow_count];
                    awaited_results.push_back(make_result(ST_REMOVED, '0, 1'b1));
                end
                else
                begin
                    awaited_results.push_back(make_result(ST_NOT_FOUND, '0, 1'b1));
                end
            end
            CMD_CLEAR:
            begin
                shadow_count = 0;
                awaited_results.push_back(make_result(ST_HIT, '0, 1'b1));
            end
            default:
            begin
                // Inclusive overlap on both axes; inverted boxes are used as given.
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_xl[i] <= c.x_high && c.x_low <= shadow_xh[i] &&
                        shadow_yl[i] <= c.y_high && c.y_low <= shadow_yh[i])
                    begin
                        awaited_results.push_back(
                            make_result(ST_HIT, shadow_tag[i], 1'b0));
                        hits++;
                    end
                end
                if (hits == 0)
                begin
                    awaited_results.push_back(make_result(ST_NO_HIT, '0, 1'b1));
                end
                else
                begin
                    r = awaited_results.pop_back();
                    r.is_last = 1'b1;
                    awaited_results.push_back(r);
                end
            end
        endcase
    endtask

    function automatic int random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
        begin
            return 0;
        end
        if (p < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Coordinates mostly from a small window so rectangles really overlap.
    function automatic logic signed [15:0] random_coord();
        if ($urandom_range(0, 9) == 0)
        begin
            return 16'($urandom());
        end
        return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
    endfunction

    function automatic command_t random_box(cmd_t k, logic [31:0] t);
        command_t c;
        logic signed [15:0] a;
        logic signed [15:0] b;
        c.cmd = k;
        c.tag = t;
        a = random_coord();
        b = random_coord();
        c.x_low  = (a <= b || $urandom_range(0, 15) == 0) ? a : b;
        c.x_high = (c.x_low == a) ? b : a;
        a = random_coord();
        b = random_coord();
        c.y_low  = (a <= b || $urandom_range(0, 15) == 0) ? a : b;
        c.y_high = (c.y_low == a) ? b : a;
        return c;
    endfunction

    function automatic command_t fixed_box(cmd_t k, logic [31:0] t, int xl, int yl,
                                           int xh, int yh);
        command_t c;
        c.cmd = k;
        c.tag = t;
        c.x_low  = 16'(xl);
        c.y_low  = 16'(yl);
        c.x_high = 16'(xh);
        c.y_high = 16'(yh);
        return c;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Remembers whether the offered transaction was taken at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= s_axis_tvalid && s_axis_tready;
        end
    end

    // Sender: offers pending commands, changes only at the falling edge.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else if (s_axis_tvalid && !in_fire)
        begin
            // Hold the current transaction until it is taken.
        end
        else if (send_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= send_gap - 1;
        end
        else if (pending_cmds.size() > 0 &&
                 !(sender_pause && awaited_results.size() > 0))
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pack_command(pending_cmds[0]);
            send_gap      <= random_gap();
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver ready, with random stalls and the long hold-off.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            hold_cycles   <= 0;
        end
        else if (hold_receiver && hold_cycles < 400)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles + 1;
        end
        else if (recv_gap > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= recv_gap - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            recv_gap      <= random_gap();
        end
    end

    // Monitor: input acceptance feeds the predictor, output is checked.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_table_results(pending_cmds.pop_front());
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status  = status_t'(m_axis_tdata[2:0]);
                got.hit_tag = m_axis_tdata[34:3];
                got.fill    = m_axis_tdata[41:35];
                got.is_last = m_axis_tlast;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result: status %0d tag %h last %b fill %0d",
                                 got.status, got.hit_tag, got.is_last, got.fill);
                    end
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected status %0d tag %h last %b fill %0d",
                                     want.status, want.hit_tag, want.is_last, want.fill);
                            $display("          actual   status %0d tag %h last %b fill %0d",
                                     got.status, got.hit_tag, got.is_last, got.fill);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || awaited_results.size() > 0 ||
               s_axis_tvalid)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int i;
        int n;
        int p;
        logic [31:0] recent_tags[$];
        logic [31:0] t;
        stimulus_done = 1'b0;
        hold_receiver = 1'b0;
        sender_pause  = 1'b0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, extremes, inverted box, duplicates, misses.
        pending_cmds.push_back(fixed_box(CMD_QUERY, 32'h0, -32768, -32768, 32767, 32767));
        pending_cmds.push_back(fixed_box(CMD_REMOVE, 32'h1234, 0, 0, 0, 0));
        pending_cmds.push_back(fixed_box(CMD_INSERT, 32'hFFFFFFFF, -32768, -32768, 32767, 32767));
        pending_cmds.push_back(fixed_box(CMD_INSERT, 32'h0, 0, 0, 0, 0));
        pending_cmds.push_back(fixed_box(CMD_INSERT, 32'hA5A5A5A5, 10, 10, -10, -10));
        pending_cmds.push_back(fixed_box(CMD_INSERT, 32'h0, 32767, 32767, 32767, 32767));
        pending_cmds.push_back(fixed_box(CMD_INSERT, 32'h5A5A5A5A, -32768, 0, -32768, 0));
        pending_cmds.push_back(fixed_box(CMD_QUERY, 32'hFFFFFFFF, 0, 0, 0, 0));
        pending_cmds.push_back(fixed_box(CMD_QUERY, 32'h0, 32767, 32767, 32767, 32767));
        pending_cmds.push_back(fixed_box(CMD_QUERY, 32'h0, -5, -5, 5, 5));
        pending_cmds.push_back(fixed_box(CMD_QUERY, 32'h0, 1, 1, -1, -1));
        pending_cmds.push_back(fixed_box(CMD_REMOVE, 32'h0, 0, 0, 0, 0));
        pending_cmds.push_back(fixed_box(CMD_QUERY, 32'h0, -32768, -32768, 32767, 32767));
        pending_cmds.push_back(fixed_box(CMD_REMOVE, 32'h77777777, 0, 0, 0, 0));
        pending_cmds.push_back(fixed_box(CMD_CLEAR, 32'hFFFFFFFF, -1, -1, -1, -1));
        pending_cmds.push_back(fixed_box(CMD_QUERY, 32'h0, -32768, -32768, 32767, 32767));
        wait_drained();

        // Fill beyond capacity while the receiver holds off, then sweep.
        hold_receiver = 1'b1;
        for (i = 0; i < CAP + 2; i++)
        begin
            pending_cmds.push_back(random_box(CMD_INSERT, $urandom_range(0, 15)));
        end
        pending_cmds.push_back(fixed_box(CMD_QUERY, 32'h0, -32768, -32768, 32767, 32767));
        wait (hold_cycles >= 400);
        wait_drained();

        // Sender pause: each command waits for every earlier result.
        sender_pause = 1'b1;
        for (i = 0; i < 6; i++)
        begin
            pending_cmds.push_back(random_box(CMD_REMOVE, $urandom_range(0, 15)));
        end
        wait_drained();
        sender_pause = 1'b0;

        // Random: mostly inserts and queries over a reused tag pool.
        for (n = 0; n < 240; n++)
        begin
            p = $urandom_range(0, 99);
            if (p < 40)
            begin
                t = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 31);
                recent_tags.push_back(t);
                if (recent_tags.size() > 16)
                begin
                    void'(recent_tags.pop_front());
                end
                pending_cmds.push_back(random_box(CMD_INSERT, t));
            end
            else if (p < 60)
            begin
                if (recent_tags.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    t = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
                end
                else
                begin
                    t = $urandom();
                end
                pending_cmds.push_back(random_box(CMD_REMOVE, t));
            end
            else if (p < 63)
            begin
                pending_cmds.push_back(random_box(CMD_CLEAR, $urandom()));
            end
            else
            begin
                pending_cmds.push_back(random_box(CMD_QUERY, $urandom()));
            end
        end
        wait_drained();
        stimulus_done = 1'b1;
        repeat (CAP + 20) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/rot_pkg.sv
sv/rot_front.sv
sv/rot_back.sv
sv/rect_overlap_table.sv
tb/rect_overlap_table_test.sv
